// ===== src/bpsd_pkg.sv =====
// Shared types, constants and field helpers for the batch point sum/difference block.
package bpsd_pkg;

    localparam int FE_W      = 256;
    localparam int LIMB_W    = 64;
    localparam int IDX_W     = 6;
    localparam int CFG_IDX_W = 4;
    localparam int BATCH_SIZE_DEF = 64;

    // secp256k1 prime and the exponent used for inversion
    localparam logic [FE_W-1:0] P =
        256'hFFFFFFFF_FFFFFFFF_FFFFFFFF_FFFFFFFF_FFFFFFFF_FFFFFFFF_FFFFFFFE_FFFFFC2F;
    localparam logic [FE_W-1:0] P_M2 = P - 256'd2;
    // 2^256 mod p = 2^32 + 977
    localparam logic [32:0] RED_C  = 33'h1_000003D1;
    localparam logic [9:0]  RED_LO = 10'd977;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_X_LIMB0 = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_Y_LIMB0 = 4'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_COUNT        = 4'd8;

    typedef enum logic [3:0] {
        OP_NONE, OP_MOV, OP_ADD, OP_SUB, OP_MUL,
        OP_LDMEM, OP_WRPRE, OP_WRRES, OP_BASE, OP_LDOUT
    } t_op;

    typedef enum logic [3:0] {
        FS_ONE, FS_PX, FS_PY, FS_TX, FS_TY, FS_PR, FS_D, FS_F,
        FS_ACC, FS_INV, FS_PSUM, FS_NUM, FS_LAM, FS_XD, FS_XS
    } t_fsel;

    typedef struct packed {
        logic  start;
        t_op   op;
        t_fsel asel;
        t_fsel bsel;
        t_fsel dsel;
        logic  wr_in;
        logic  zero_out;
    } t_cmd;

    typedef struct packed {
        logic done;
        logic d_zero;
    } t_stat;

    typedef enum logic [4:0] {
        ST_LOAD, ST_BASE,
        ST_F_LD, ST_F_SUB, ST_F_PROD, ST_F_WR,
        ST_I_INIT, ST_I_SQR, ST_I_MUL,
        ST_B_LD, ST_B_SUB, ST_B_INV, ST_B_ACC, ST_B_MOV,
        ST_B_PSUM, ST_B_NUMA, ST_B_LAMA, ST_B_SQA, ST_B_XD,
        ST_B_NUMS, ST_B_LAMS, ST_B_SQS, ST_B_XS, ST_B_WR,
        ST_O_LD, ST_O_SEND
    } t_state;

    typedef enum logic [2:0] {
        MS_IDLE, MS_PROD, MS_FLUSH, MS_FOLD, MS_FIX1, MS_FIX2, MS_FIX3
    } t_mstate;

    // bring a value below 2^256 into [0, p) with one subtraction
    function automatic logic [FE_W-1:0] fe_red(input logic [FE_W-1:0] v);
        logic [FE_W:0] t;
        t = {1'b0, v} - {1'b0, P};
        return t[FE_W] ? v : t[FE_W-1:0];
    endfunction

endpackage

// ===== src/batch_point_sum_difference_x_top.sv =====
// Top level of the batch point sum/difference block (secp256k1, batch inversion).
//
// The block collects a batch of affine points T (one per input transaction, up to
// BATCH_SIZE; tlast or a full batch closes it) and, against the fixed point P held in
// the configuration registers, returns x(P-T) and x(P+T) for every point, in arrival
// order, with tlast on the last one. Coordinates at or above p are reduced once on
// entry. All field multiplications run on one shared multiplier built around a single
// 32x32 multiplier; a field multiplication has an issue step, a partial-product phase,
// a flush, a word-serial fold and a final fix-up. A batch of n points takes a forward
// sweep, one inversion of 505 multiplications (256 squarings plus one per set bit of
// p-2) and a backward sweep of up to six multiplications per point plus the loads,
// additions and subtractions, all before the first result. Each result is then read
// from the result store and offered, and the next is not read until the receiver has
// taken it. No input transaction is taken while a batch is in work. If any
// denominator P.x-T.x is zero the batch gives a single result with tuser high, zero
// coordinates and the first offending index, and the batch is dropped.
module batch_point_sum_difference_x_top #(
    parameter int BATCH_SIZE = bpsd_pkg::BATCH_SIZE_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // fields from bit 0: pt_x0, pt_x1, pt_x2, pt_x3, pt_y0, pt_y1, pt_y2, pt_y3
    input  logic [511:0]                  s_axis_tdata,
    input  logic                          s_axis_tvalid,
    input  logic                          s_axis_tlast,
    output logic                          s_axis_tready,
    // fields from bit 0: xdiff0..3, xsum0..3, point_index, two zero pad bits
    output logic [519:0]                  m_axis_tdata,
    // fields from bit 0: zero_denominator
    output logic                          m_axis_tuser,
    output logic                          m_axis_tlast,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    input  logic                          i_cfg_we,
    input  logic [bpsd_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [bpsd_pkg::LIMB_W-1:0]   i_cfg_data
);
    import bpsd_pkg::*;

    localparam int AW = (BATCH_SIZE > 1) ? $clog2(BATCH_SIZE) : 1;

    t_cmd              w_cmd;
    t_stat             w_stat;
    logic [AW-1:0]     w_addr;
    logic [IDX_W-1:0]  w_index;
    logic [FE_W-1:0]   w_xdiff, w_xsum;

    // sequencing of the batch; one command to the datapath at a time
    bpsd_ctrl #(.BATCH_SIZE(BATCH_SIZE)) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (s_axis_tvalid),
        .i_s_last  (s_axis_tlast),
        .i_m_ready (m_axis_tready),
        .i_stat    (w_stat),
        .o_s_ready (s_axis_tready),
        .o_m_valid (m_axis_tvalid),
        .o_m_last  (m_axis_tlast),
        .o_m_zero  (m_axis_tuser),
        .o_m_index (w_index),
        .o_cmd     (w_cmd),
        .o_addr    (w_addr)
    );

    // field arithmetic, point stores, prefix store and result store
    bpsd_dpath #(.BATCH_SIZE(BATCH_SIZE)) u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .i_addr     (w_addr),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_pt_x     (s_axis_tdata[255:0]),
        .i_pt_y     (s_axis_tdata[511:256]),
        .o_stat     (w_stat),
        .o_xdiff    (w_xdiff),
        .o_xsum     (w_xsum)
    );

    // pack the result; pad to whole bytes
    assign m_axis_tdata = {2'b00, w_index, w_xsum, w_xdiff};
endmodule

// ===== src/bpsd_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module bpsd_ram #(
    parameter int WIDTH = 256,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== src/bpsd_fmul.sv =====
// Field multiplier mod p: 32x32 product scanning, word-serial fold, final fix-up.
module bpsd_fmul (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [bpsd_pkg::FE_W-1:0] i_a,
    input  logic [bpsd_pkg::FE_W-1:0] i_b,
    output logic                  o_done,
    output logic [bpsd_pkg::FE_W-1:0] o_res
);
    import bpsd_pkg::*;

    t_mstate      r_ph, n_ph;
    logic [3:0]   r_col;
    logic [2:0]   r_i;
    logic [63:0]  r_pp;
    logic         r_pp_v, r_pp_end, r_pp_fin;
    logic [3:0]   r_pp_col;
    logic [69:0]  r_cacc;
    logic [511:0] r_t;
    logic [3:0]   r_w;
    logic [11:0]  r_fc;
    logic [255:0] r_r;
    logic [32:0]  r_top;
    logic [256:0] r_v;

    logic [2:0]   w_ihi, w_j, w_ilo_nx;
    logic [3:0]   w_col_nx;
    logic         w_last_pair;
    logic [69:0]  w_sum;
    logic [31:0]  w_tw [16];
    logic [31:0]  w_lo, w_hi, w_prev;
    logic [43:0]  w_fs;

    assign w_ihi       = (r_col > 4'd7) ? 3'd7 : r_col[2:0];
    assign w_j         = 3'(r_col - {1'b0, r_i});
    assign w_col_nx    = r_col + 4'd1;
    assign w_ilo_nx    = (w_col_nx > 4'd7) ? 3'(w_col_nx - 4'd7) : 3'd0;
    assign w_last_pair = (r_i == w_ihi) && (r_col == 4'd14);
    assign w_sum       = r_cacc + 70'(r_pp);

    always_comb begin
        for (int k = 0; k < 16; k++) begin
            w_tw[k] = r_t[k*32 +: 32];
        end
    end

    // word w of lo + hi*977 + (hi << 32)
    assign w_lo   = r_w[3] ? 32'd0 : w_tw[{1'b0, r_w[2:0]}];
    assign w_hi   = r_w[3] ? 32'd0 : w_tw[{1'b1, r_w[2:0]}];
    assign w_prev = (r_w == 4'd0) ? 32'd0 : w_tw[{1'b1, 3'(r_w - 4'd1)}];
    assign w_fs   = 44'(w_lo) + 44'(w_hi) * 44'(RED_LO) + 44'(w_prev) + 44'(r_fc);

    always_comb begin
        n_ph = r_ph;
        case (r_ph)
            MS_IDLE:  if (i_start) n_ph = MS_PROD;
            MS_PROD:  if (w_last_pair) n_ph = MS_FLUSH;
            MS_FLUSH: if (r_pp_v && r_pp_fin) n_ph = MS_FOLD;
            MS_FOLD:  if (r_w == 4'd8) n_ph = MS_FIX1;
            MS_FIX1:  n_ph = MS_FIX2;
            MS_FIX2:  n_ph = MS_FIX3;
            MS_FIX3:  n_ph = MS_IDLE;
            default:  n_ph = MS_IDLE;
        endcase
    end

    always_comb begin
        o_done = (r_ph == MS_FIX3);
        o_res  = fe_red(r_v[255:0]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph   <= MS_IDLE;
            r_pp_v <= 1'b0;
        end else begin
            r_ph   <= n_ph;
            r_pp_v <= (r_ph == MS_PROD);
        end
    end

    always_ff @(posedge i_clk) begin
        // partial product stage
        r_pp     <= 64'(i_a[r_i*32 +: 32]) * 64'(i_b[w_j*32 +: 32]);
        r_pp_end <= (r_i == w_ihi);
        r_pp_fin <= w_last_pair;
        r_pp_col <= r_col;
        if (r_ph == MS_IDLE) begin
            r_col  <= 4'd0;
            r_i    <= 3'd0;
            r_cacc <= 70'd0;
        end else if (r_ph == MS_PROD) begin
            if (r_i == w_ihi) begin
                r_col <= w_col_nx;
                r_i   <= w_ilo_nx;
            end else begin
                r_i <= r_i + 3'd1;
            end
        end
        // column accumulate stage
        if (r_pp_v) begin
            if (r_pp_end) begin
                r_t[r_pp_col*32 +: 32] <= w_sum[31:0];
                r_cacc <= w_sum >> 32;
                if (r_pp_fin) begin
                    r_t[511:480] <= w_sum[63:32];
                end
            end else begin
                r_cacc <= w_sum;
            end
        end
        // fold of the high half
        if (r_ph != MS_FOLD) begin
            r_w  <= 4'd0;
            r_fc <= 12'd0;
        end else begin
            r_w  <= r_w + 4'd1;
            r_fc <= w_fs[43:32];
            if (r_w[3]) begin
                r_top <= w_fs[32:0];
            end else begin
                r_r[r_w[2:0]*32 +: 32] <= w_fs[31:0];
            end
        end
        if (r_ph == MS_FIX1) begin
            r_v <= {1'b0, r_r} + 257'(r_top) * 257'(RED_LO) + 257'({r_top, 32'd0});
        end else if (r_ph == MS_FIX2 && r_v[256]) begin
            r_v <= {1'b0, r_v[255:0] + 256'(RED_C)};
        end
    end
endmodule

// ===== src/bpsd_dpath.sv =====
// Datapath: field registers, add/sub unit, multiplier, point and result stores.
module bpsd_dpath #(
    parameter int BATCH_SIZE = bpsd_pkg::BATCH_SIZE_DEF,
    localparam int AW = (BATCH_SIZE > 1) ? $clog2(BATCH_SIZE) : 1
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  bpsd_pkg::t_cmd                i_cmd,
    input  logic [AW-1:0]                 i_addr,
    input  logic                          i_cfg_we,
    input  logic [bpsd_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [bpsd_pkg::LIMB_W-1:0]   i_cfg_data,
    input  logic [bpsd_pkg::FE_W-1:0]     i_pt_x,
    input  logic [bpsd_pkg::FE_W-1:0]     i_pt_y,
    output bpsd_pkg::t_stat               o_stat,
    output logic [bpsd_pkg::FE_W-1:0]     o_xdiff,
    output logic [bpsd_pkg::FE_W-1:0]     o_xsum
);
    import bpsd_pkg::*;

    logic [LIMB_W-1:0] r_bx [4];
    logic [LIMB_W-1:0] r_by [4];
    logic [FE_W-1:0] r_px, r_py, r_tx, r_ty, r_pr, r_d, r_f, r_acc, r_inv;
    logic [FE_W-1:0] r_psum, r_num, r_lam, r_xd, r_xs, r_out_xd, r_out_xs;
    logic [FE_W:0]   r_as;
    logic            r_as_busy, r_as_sub, r_pend;

    logic [FE_W-1:0] w_a, w_b, w_val, w_as_fix, w_mul_res, w_xrd, w_yrd, w_prd;
    logic [FE_W+1:0] w_as_t;
    logic [2*FE_W-1:0] w_rrd;
    logic            w_wr, w_mul_done, w_start;

    assign w_start = i_cmd.start;

    always_comb begin
        case (i_cmd.asel)
            FS_ONE:  w_a = 256'd1;
            FS_PX:   w_a = r_px;
            FS_PY:   w_a = r_py;
            FS_TX:   w_a = r_tx;
            FS_TY:   w_a = r_ty;
            FS_PR:   w_a = r_pr;
            FS_D:    w_a = r_d;
            FS_F:    w_a = r_f;
            FS_ACC:  w_a = r_acc;
            FS_INV:  w_a = r_inv;
            FS_PSUM: w_a = r_psum;
            FS_NUM:  w_a = r_num;
            FS_LAM:  w_a = r_lam;
            FS_XD:   w_a = r_xd;
            FS_XS:   w_a = r_xs;
            default: w_a = '0;
        endcase
        case (i_cmd.bsel)
            FS_ONE:  w_b = 256'd1;
            FS_PX:   w_b = r_px;
            FS_PY:   w_b = r_py;
            FS_TX:   w_b = r_tx;
            FS_TY:   w_b = r_ty;
            FS_PR:   w_b = r_pr;
            FS_D:    w_b = r_d;
            FS_F:    w_b = r_f;
            FS_ACC:  w_b = r_acc;
            FS_INV:  w_b = r_inv;
            FS_PSUM: w_b = r_psum;
            FS_NUM:  w_b = r_num;
            FS_LAM:  w_b = r_lam;
            FS_XD:   w_b = r_xd;
            FS_XS:   w_b = r_xs;
            default: w_b = '0;
        endcase
    end

    // second step of add/sub: bring the raw sum or difference back into range
    assign w_as_t = {1'b0, r_as} - {2'b0, P};
    always_comb begin
        if (r_as_sub) begin
            w_as_fix = r_as[FE_W] ? r_as[FE_W-1:0] + P : r_as[FE_W-1:0];
        end else begin
            w_as_fix = w_as_t[FE_W+1] ? r_as[FE_W-1:0] : w_as_t[FE_W-1:0];
        end
    end

    bpsd_fmul u_fmul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start && i_cmd.op == OP_MUL),
        .i_a     (w_a),
        .i_b     (w_b),
        .o_done  (w_mul_done),
        .o_res   (w_mul_res)
    );

    bpsd_ram #(.WIDTH(FE_W), .DEPTH(BATCH_SIZE)) u_xmem (
        .i_clk(i_clk), .i_we(i_cmd.wr_in), .i_waddr(i_addr), .i_wdata(fe_red(i_pt_x)),
        .i_raddr(i_addr), .o_rdata(w_xrd)
    );
    bpsd_ram #(.WIDTH(FE_W), .DEPTH(BATCH_SIZE)) u_ymem (
        .i_clk(i_clk), .i_we(i_cmd.wr_in), .i_waddr(i_addr), .i_wdata(fe_red(i_pt_y)),
        .i_raddr(i_addr), .o_rdata(w_yrd)
    );
    bpsd_ram #(.WIDTH(FE_W), .DEPTH(BATCH_SIZE)) u_pmem (
        .i_clk(i_clk), .i_we(w_start && i_cmd.op == OP_WRPRE), .i_waddr(i_addr),
        .i_wdata(r_f), .i_raddr(i_addr - AW'(1)), .o_rdata(w_prd)
    );
    bpsd_ram #(.WIDTH(2*FE_W), .DEPTH(BATCH_SIZE)) u_rmem (
        .i_clk(i_clk), .i_we(w_start && i_cmd.op == OP_WRRES), .i_waddr(i_addr),
        .i_wdata({r_xs, r_xd}), .i_raddr(i_addr), .o_rdata(w_rrd)
    );

    always_comb begin
        w_wr  = 1'b0;
        w_val = w_a;
        if (w_mul_done) begin
            w_wr  = 1'b1;
            w_val = w_mul_res;
        end else if (r_as_busy) begin
            w_wr  = 1'b1;
            w_val = w_as_fix;
        end else if (w_start && i_cmd.op == OP_MOV) begin
            w_wr = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_as_busy <= 1'b0;
            r_pend    <= 1'b0;
            for (int k = 0; k < 4; k++) begin
                r_bx[k] <= '0;
                r_by[k] <= '0;
            end
        end else begin
            r_as_busy <= w_start && (i_cmd.op == OP_ADD || i_cmd.op == OP_SUB);
            r_pend    <= w_start && (i_cmd.op == OP_MOV || i_cmd.op == OP_LDMEM
                         || i_cmd.op == OP_WRPRE || i_cmd.op == OP_WRRES
                         || i_cmd.op == OP_BASE || i_cmd.op == OP_LDOUT);
            if (i_cfg_we && i_cfg_idx < CFG_BASE_Y_LIMB0) begin
                r_bx[i_cfg_idx[1:0]] <= i_cfg_data;
            end else if (i_cfg_we && i_cfg_idx < CFG_COUNT) begin
                r_by[i_cfg_idx[1:0]] <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_start && (i_cmd.op == OP_ADD || i_cmd.op == OP_SUB)) begin
            r_as_sub <= (i_cmd.op == OP_SUB);
            r_as     <= (i_cmd.op == OP_SUB) ? {1'b0, w_a} - {1'b0, w_b}
                                             : {1'b0, w_a} + {1'b0, w_b};
        end
        if (w_start && i_cmd.op == OP_BASE) begin
            r_px <= fe_red({r_bx[3], r_bx[2], r_bx[1], r_bx[0]});
            r_py <= fe_red({r_by[3], r_by[2], r_by[1], r_by[0]});
        end
        if (r_pend && i_cmd.op == OP_LDMEM) begin
            r_tx <= w_xrd;
            r_ty <= w_yrd;
            r_pr <= w_prd;
        end
        if (r_pend && i_cmd.op == OP_LDOUT) begin
            r_out_xd <= i_cmd.zero_out ? '0 : w_rrd[FE_W-1:0];
            r_out_xs <= i_cmd.zero_out ? '0 : w_rrd[2*FE_W-1:FE_W];
        end
        if (w_wr) begin
            case (i_cmd.dsel)
                FS_D:    r_d    <= w_val;
                FS_F:    r_f    <= w_val;
                FS_ACC:  r_acc  <= w_val;
                FS_INV:  r_inv  <= w_val;
                FS_PSUM: r_psum <= w_val;
                FS_NUM:  r_num  <= w_val;
                FS_LAM:  r_lam  <= w_val;
                FS_XD:   r_xd   <= w_val;
                FS_XS:   r_xs   <= w_val;
                default: ;
            endcase
        end
    end

    assign o_stat.done   = r_pend || r_as_busy || w_mul_done;
    assign o_stat.d_zero = (r_d == '0);
    assign o_xdiff = r_out_xd;
    assign o_xsum  = r_out_xs;
endmodule

// ===== src/bpsd_ctrl.sv =====
// Controller: batch loading, forward prefix sweep, inversion, backward sweep, output.
module bpsd_ctrl #(
    parameter int BATCH_SIZE = bpsd_pkg::BATCH_SIZE_DEF,
    localparam int AW = (BATCH_SIZE > 1) ? $clog2(BATCH_SIZE) : 1
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_s_valid,
    input  logic                        i_s_last,
    input  logic                        i_m_ready,
    input  bpsd_pkg::t_stat             i_stat,
    output logic                        o_s_ready,
    output logic                        o_m_valid,
    output logic                        o_m_last,
    output logic                        o_m_zero,
    output logic [bpsd_pkg::IDX_W-1:0]  o_m_index,
    output bpsd_pkg::t_cmd              o_cmd,
    output logic [AW-1:0]               o_addr
);
    import bpsd_pkg::*;

    t_state        r_state, n_state;
    logic          r_wait, r_zseen;
    logic [AW-1:0] r_k, r_last, r_zpos;
    logic [7:0]    r_bit;
    logic          w_compute, w_acc_in, w_end_in, w_done, w_k_last;

    assign w_compute = (r_state != ST_LOAD) && (r_state != ST_O_SEND);
    assign w_acc_in  = (r_state == ST_LOAD) && i_s_valid;
    assign w_end_in  = i_s_last || (r_k == AW'(BATCH_SIZE - 1));
    assign w_done    = i_stat.done;
    assign w_k_last  = (r_k == r_last);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_LOAD:   if (w_acc_in && w_end_in) n_state = ST_BASE;
            ST_O_SEND: if (i_m_ready) n_state = (r_zseen || w_k_last) ? ST_LOAD : ST_O_LD;
            default: begin
                if (w_done) begin
                    case (r_state)
                        ST_BASE:   n_state = ST_F_LD;
                        ST_F_LD:   n_state = ST_F_SUB;
                        ST_F_SUB:  n_state = ST_F_PROD;
                        ST_F_PROD: n_state = ST_F_WR;
                        ST_F_WR:   n_state = !w_k_last ? ST_F_LD
                                           : (r_zseen ? ST_O_LD : ST_I_INIT);
                        ST_I_INIT: n_state = ST_I_SQR;
                        ST_I_SQR:  n_state = P_M2[r_bit] ? ST_I_MUL
                                           : ((r_bit == 8'd0) ? ST_B_LD : ST_I_SQR);
                        ST_I_MUL:  n_state = (r_bit == 8'd0) ? ST_B_LD : ST_I_SQR;
                        ST_B_LD:   n_state = (r_k != '0) ? ST_B_SUB : ST_B_MOV;
                        ST_B_SUB:  n_state = ST_B_INV;
                        ST_B_INV:  n_state = ST_B_ACC;
                        ST_B_ACC:  n_state = ST_B_PSUM;
                        ST_B_MOV:  n_state = ST_B_PSUM;
                        ST_B_PSUM: n_state = ST_B_NUMA;
                        ST_B_NUMA: n_state = ST_B_LAMA;
                        ST_B_LAMA: n_state = ST_B_SQA;
                        ST_B_SQA:  n_state = ST_B_XD;
                        ST_B_XD:   n_state = ST_B_NUMS;
                        ST_B_NUMS: n_state = ST_B_LAMS;
                        ST_B_LAMS: n_state = ST_B_SQS;
                        ST_B_SQS:  n_state = ST_B_XS;
                        ST_B_XS:   n_state = ST_B_WR;
                        ST_B_WR:   n_state = (r_k != '0) ? ST_B_LD : ST_O_LD;
                        ST_O_LD:   n_state = ST_O_SEND;
                        default:   n_state = ST_LOAD;
                    endcase
                end
            end
        endcase
    end

    // command outputs
    always_comb begin
        o_cmd          = '0;
        o_cmd.start    = w_compute && !r_wait;
        o_cmd.op       = OP_NONE;
        o_cmd.asel     = FS_ONE;
        o_cmd.bsel     = FS_ONE;
        o_cmd.dsel     = FS_ONE;
        o_cmd.wr_in    = w_acc_in;
        o_cmd.zero_out = r_zseen;
        case (r_state)
            ST_BASE:   o_cmd.op = OP_BASE;
            ST_F_LD:   o_cmd.op = OP_LDMEM;
            ST_F_SUB:  begin o_cmd.op = OP_SUB; o_cmd.asel = FS_PX; o_cmd.bsel = FS_TX;
                             o_cmd.dsel = FS_D; end
            ST_F_PROD: begin
                o_cmd.op   = (r_k == '0) ? OP_MOV : OP_MUL;
                o_cmd.asel = (r_k == '0) ? FS_D : FS_F;
                o_cmd.bsel = FS_D;
                o_cmd.dsel = FS_F;
            end
            ST_F_WR:   o_cmd.op = OP_WRPRE;
            ST_I_INIT: begin o_cmd.op = OP_MOV; o_cmd.dsel = FS_ACC; end
            ST_I_SQR:  begin o_cmd.op = OP_MUL; o_cmd.asel = FS_ACC; o_cmd.bsel = FS_ACC;
                             o_cmd.dsel = FS_ACC; end
            ST_I_MUL:  begin o_cmd.op = OP_MUL; o_cmd.asel = FS_ACC; o_cmd.bsel = FS_F;
                             o_cmd.dsel = FS_ACC; end
            ST_B_LD:   o_cmd.op = OP_LDMEM;
            ST_B_SUB:  begin o_cmd.op = OP_SUB; o_cmd.asel = FS_PX; o_cmd.bsel = FS_TX;
                             o_cmd.dsel = FS_D; end
            ST_B_INV:  begin o_cmd.op = OP_MUL; o_cmd.asel = FS_PR; o_cmd.bsel = FS_ACC;
                             o_cmd.dsel = FS_INV; end
            ST_B_ACC:  begin o_cmd.op = OP_MUL; o_cmd.asel = FS_ACC; o_cmd.bsel = FS_D;
                             o_cmd.dsel = FS_ACC; end
            ST_B_MOV:  begin o_cmd.op = OP_MOV; o_cmd.asel = FS_ACC; o_cmd.dsel = FS_INV; end
            ST_B_PSUM: begin o_cmd.op = OP_ADD; o_cmd.asel = FS_PX; o_cmd.bsel = FS_TX;
                             o_cmd.dsel = FS_PSUM; end
            ST_B_NUMA: begin o_cmd.op = OP_ADD; o_cmd.asel = FS_PY; o_cmd.bsel = FS_TY;
                             o_cmd.dsel = FS_NUM; end
            ST_B_LAMA: begin o_cmd.op = OP_MUL; o_cmd.asel = FS_NUM; o_cmd.bsel = FS_INV;
                             o_cmd.dsel = FS_LAM; end
            ST_B_SQA:  begin o_cmd.op = OP_MUL; o_cmd.asel = FS_LAM; o_cmd.bsel = FS_LAM;
                             o_cmd.dsel = FS_XD; end
            ST_B_XD:   begin o_cmd.op = OP_SUB; o_cmd.asel = FS_XD; o_cmd.bsel = FS_PSUM;
                             o_cmd.dsel = FS_XD; end
            ST_B_NUMS: begin o_cmd.op = OP_SUB; o_cmd.asel = FS_PY; o_cmd.bsel = FS_TY;
                             o_cmd.dsel = FS_NUM; end
            ST_B_LAMS: begin o_cmd.op = OP_MUL; o_cmd.asel = FS_NUM; o_cmd.bsel = FS_INV;
                             o_cmd.dsel = FS_LAM; end
            ST_B_SQS:  begin o_cmd.op = OP_MUL; o_cmd.asel = FS_LAM; o_cmd.bsel = FS_LAM;
                             o_cmd.dsel = FS_XS; end
            ST_B_XS:   begin o_cmd.op = OP_SUB; o_cmd.asel = FS_XS; o_cmd.bsel = FS_PSUM;
                             o_cmd.dsel = FS_XS; end
            ST_B_WR:   o_cmd.op = OP_WRRES;
            ST_O_LD:   o_cmd.op = OP_LDOUT;
            default:   o_cmd.op = OP_NONE;
        endcase
    end

    assign o_addr    = r_k;
    assign o_s_ready = (r_state == ST_LOAD);
    assign o_m_valid = (r_state == ST_O_SEND);
    assign o_m_zero  = r_zseen;
    assign o_m_last  = r_zseen || w_k_last;
    assign o_m_index = IDX_W'(r_zseen ? r_zpos : r_k);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
            r_wait  <= 1'b0;
            r_k     <= '0;
            r_last  <= '0;
            r_zseen <= 1'b0;
            r_zpos  <= '0;
            r_bit   <= 8'd255;
        end else begin
            r_state <= n_state;
            r_wait  <= w_compute && !w_done;
            case (r_state)
                ST_LOAD: begin
                    if (w_acc_in) begin
                        if (w_end_in) begin
                            r_last <= r_k;
                            r_k    <= '0;
                        end else begin
                            r_k <= r_k + AW'(1);
                        end
                    end
                end
                ST_F_PROD: begin
                    if (o_cmd.start && i_stat.d_zero && !r_zseen) begin
                        r_zseen <= 1'b1;
                        r_zpos  <= r_k;
                    end
                end
                ST_F_WR: begin
                    if (w_done) begin
                        if (!w_k_last) r_k <= r_k + AW'(1);
                        r_bit <= 8'd255;
                    end
                end
                ST_I_SQR, ST_I_MUL: begin
                    if (w_done && (r_state == ST_I_MUL || !P_M2[r_bit])) begin
                        if (r_bit == 8'd0) r_k <= r_last;
                        else r_bit <= r_bit - 8'd1;
                    end
                end
                ST_B_WR: begin
                    if (w_done && r_k != '0) r_k <= r_k - AW'(1);
                end
                ST_O_SEND: begin
                    if (i_m_ready) begin
                        if (r_zseen || w_k_last) begin
                            r_k     <= '0;
                            r_zseen <= 1'b0;
                            r_zpos  <= '0;
                        end else begin
                            r_k <= r_k + AW'(1);
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // a result and an input are never open together
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_m_valid && o_s_ready))
        else $error("result offered while input is open");

    // datapath completion only answers an issued command
    a_done_issued: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_stat.done |-> r_wait)
        else $error("datapath completion without an issued command");

    // a flagged zero result closes the batch
    a_zero_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_valid && o_m_zero) |-> o_m_last)
        else $error("zero-denominator result not marked last");
endmodule

// ===== test/tb.sv =====
// Testbench for the batch point sum/difference block: directed and random batches.
`timescale 1ns / 100ps

module tb;
    import bpsd_pkg::*;

    localparam int      N_RANDOM   = 85;
    localparam longint  CYCLE_CAP  = 6000000;
    localparam int      DRAIN_WAIT = 200;

    typedef struct {
        logic [FE_W-1:0]  xdiff;
        logic [FE_W-1:0]  xsum;
        logic [IDX_W-1:0] index;
        logic             zero_den;
        logic             last;
    } t_point_result;

    logic         i_clk;
    logic         i_rst_n;
    // fields from bit 0: pt_x0..3, pt_y0..3
    logic [511:0] s_axis_tdata;
    logic         s_axis_tvalid;
    logic         s_axis_tlast;
    logic         s_axis_tready;
    // fields from bit 0: xdiff0..3, xsum0..3, point_index, pad
    logic [519:0] m_axis_tdata;
    // fields from bit 0: zero_denominator
    logic         m_axis_tuser;
    logic         m_axis_tlast;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic         i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [LIMB_W-1:0]    i_cfg_data;

    batch_point_sum_difference_x_top uut (.*);

    // predictor state: registers as written, and the points of the open batch
    logic [LIMB_W-1:0] base_regs [8];
    logic [FE_W-1:0]   open_x [$];
    logic [FE_W-1:0]   open_y [$];
    t_point_result     pending_results [$];

    int     mismatches;
    longint cycles;
    int     burst_left;
    int     stall_phase;
    int     stall_mode;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // hang guard
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // receiver: alternate stretches of full readiness, light and heavy stalling
    always @(posedge i_clk) begin
        if (stall_phase == 0) begin
            stall_mode  <= $urandom_range(0, 2);
            stall_phase <= $urandom_range(50, 400);
        end else begin
            stall_phase <= stall_phase - 1;
        end
        case (stall_mode)
            0: m_axis_tready <= 1'b1;
            1: m_axis_tready <= ($urandom_range(0, 3) != 0);
            default: m_axis_tready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    // ---------------- field arithmetic, mod p ----------------
    function automatic logic [FE_W-1:0] mod_reduce_once(input logic [FE_W-1:0] v);
        return (v >= P) ? v - P : v;
    endfunction

    function automatic logic [FE_W-1:0] mod_mul(input logic [FE_W-1:0] a, b);
        logic [2*FE_W-1:0] wide;
        wide = {{FE_W{1'b0}}, a} * {{FE_W{1'b0}}, b};
        return FE_W'(wide % {{FE_W{1'b0}}, P});
    endfunction

    function automatic logic [FE_W-1:0] mod_add(input logic [FE_W-1:0] a, b);
        logic [FE_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= {1'b0, P}) s = s - {1'b0, P};
        return s[FE_W-1:0];
    endfunction

    function automatic logic [FE_W-1:0] mod_sub(input logic [FE_W-1:0] a, b);
        logic [FE_W:0] s;
        s = (a >= b) ? {1'b0, a} - {1'b0, b} : {1'b0, a} + {1'b0, P} - {1'b0, b};
        return s[FE_W-1:0];
    endfunction

    // Fermat inversion, a^(p-2)
    function automatic logic [FE_W-1:0] mod_inv(input logic [FE_W-1:0] a);
        logic [FE_W-1:0] r;
        r = 1;
        for (int i = FE_W - 1; i >= 0; i--) begin
            r = mod_mul(r, r);
            if (P_M2[i]) r = mod_mul(r, a);
        end
        return r;
    endfunction

    // close the open batch: queue the x coordinates of P-T and P+T for every point
    task automatic close_batch();
        logic [FE_W-1:0] px, py, tx, ty, d, inv, psum, lam;
        t_point_result   r;
        int              first_zero;
        px = mod_reduce_once({base_regs[3], base_regs[2], base_regs[1], base_regs[0]});
        py = mod_reduce_once({base_regs[7], base_regs[6], base_regs[5], base_regs[4]});
        first_zero = -1;
        foreach (open_x[k])
            if (first_zero < 0 && mod_reduce_once(open_x[k]) == px) first_zero = k;
        if (first_zero >= 0) begin
            r.xdiff = '0; r.xsum = '0; r.index = IDX_W'(first_zero);
            r.zero_den = 1'b1; r.last = 1'b1;
            pending_results.push_back(r);
        end else begin
            foreach (open_x[k]) begin
                tx   = mod_reduce_once(open_x[k]);
                ty   = mod_reduce_once(open_y[k]);
                d    = mod_sub(px, tx);
                inv  = mod_inv(d);
                psum = mod_add(px, tx);
                lam  = mod_mul(mod_add(py, ty), inv);
                r.xdiff = mod_sub(mod_mul(lam, lam), psum);
                lam  = mod_mul(mod_sub(py, ty), inv);
                r.xsum = mod_sub(mod_mul(lam, lam), psum);
                r.index = IDX_W'(k);
                r.zero_den = 1'b0;
                r.last = (k == open_x.size() - 1);
                pending_results.push_back(r);
            end
        end
        open_x.delete();
        open_y.delete();
    endtask

    // result checker: a transaction seen at the falling edge completes at the next rising edge
    always @(negedge i_clk) begin
        t_point_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h", m_axis_tdata);
            end else begin
                want = pending_results.pop_front();
                if (m_axis_tdata[255:0] !== want.xdiff || m_axis_tdata[511:256] !== want.xsum
                    || m_axis_tdata[517:512] !== want.index
                    || m_axis_tuser !== want.zero_den || m_axis_tlast !== want.last) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("mismatch idx exp %0d got %0d, zero exp %b got %b, last exp %b got %b",
                                 want.index, m_axis_tdata[517:512], want.zero_den,
                                 m_axis_tuser, want.last, m_axis_tlast);
                        $display("  xdiff exp %h got %h", want.xdiff, m_axis_tdata[255:0]);
                        $display("  xsum  exp %h got %h", want.xsum, m_axis_tdata[511:256]);
                    end
                end
            end
        end
    end

    // ---------------- stimulus helpers ----------------
    function automatic logic [FE_W-1:0] random_coord();
        logic [FE_W-1:0] v;
        v = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        case ($urandom_range(0, 9))
            0: v = '0;
            1: v = '1;
            2: v = P + $urandom_range(0, 1000);   // not below p, reduced on entry
            3: v = P - 1;
            default: ;
        endcase
        return v;
    endfunction

    // send one point; bursts of random length with random gaps between them
    task automatic send_point(input logic [FE_W-1:0] x, y, input logic last);
        logic took;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            if ($urandom_range(0, 2) != 0) begin
                s_axis_tvalid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {y, x};
        s_axis_tlast  <= last;
        do begin
            @(negedge i_clk);
            took = s_axis_tready;
            @(posedge i_clk);
        end while (!took);
        open_x.push_back(x);
        open_y.push_back(y);
        if (last || open_x.size() == BATCH_SIZE_DEF) close_batch();
    endtask

    task automatic hold_until_idle();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic write_reg(input int idx, input logic [LIMB_W-1:0] value);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_IDX_W'(idx);
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        if (idx < 8) base_regs[idx] = value;
    endtask

    task automatic load_base(input logic [FE_W-1:0] x, y);
        for (int i = 0; i < 4; i++) begin
            write_reg(CFG_BASE_X_LIMB0 + i, x[64*i +: 64]);
            write_reg(CFG_BASE_Y_LIMB0 + i, y[64*i +: 64]);
        end
    endtask

    // ---------------- tests ----------------
    task automatic test_single_point();
        // reset base: P = (0, 0)
        send_point(random_coord() | 256'd1, random_coord(), 1'b1);
        hold_until_idle();
    endtask

    task automatic test_coords_not_below_p();
        // base coordinates all ones, taken as all ones minus p
        load_base('1, '1);
        send_point('0, '0, 1'b0);
        send_point(P + 5, '1, 1'b0);
        send_point(P - 1, P, 1'b0);
        send_point(256'd1, P - 1, 1'b1);
        hold_until_idle();
    endtask

    task automatic test_zero_denominator();
        logic [FE_W-1:0] bx;
        bx = random_coord();
        load_base(bx, random_coord());
        send_point(random_coord() ^ 256'd1 ^ bx, random_coord(), 1'b0);
        send_point(random_coord() ^ 256'd2 ^ bx, random_coord(), 1'b0);
        send_point(bx, random_coord(), 1'b0);        // first equal x
        send_point(bx, random_coord(), 1'b1);        // second equal x, not reported
        hold_until_idle();
        // equal only after reduction
        load_base(256'd7, 256'd11);
        send_point(P + 7, '0, 1'b1);
        hold_until_idle();
    endtask

    task automatic test_unused_register_index();
        for (int i = 8; i < 16; i++) write_reg(i, {$urandom, $urandom});
        send_point(256'd3, 256'd5, 1'b0);
        send_point(random_coord(), random_coord(), 1'b1);
        hold_until_idle();
    endtask

    task automatic test_full_batch();
        load_base(random_coord(), random_coord());
        // no tlast: the 64th point closes the batch by itself
        for (int i = 0; i < BATCH_SIZE_DEF; i++)
            send_point(random_coord(), random_coord(), 1'b0);
        send_point(random_coord(), random_coord(), 1'b1);
        hold_until_idle();
    endtask

    task automatic test_random_batches();
        int sent, size;
        logic [FE_W-1:0] x;
        sent = 0;
        while (sent < N_RANDOM) begin
            load_base(random_coord(), random_coord());
            size = ($urandom_range(0, 7) == 0) ? 1 : $urandom_range(8, 40);
            for (int i = 0; i < size; i++) begin
                x = random_coord();
                if ($urandom_range(0, 150) == 0)
                    x = {base_regs[3], base_regs[2], base_regs[1], base_regs[0]};
                send_point(x, random_coord(), i == size - 1);
            end
            sent += size;
            hold_until_idle();
        end
    endtask

    initial begin
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tlast  <= 1'b0;
        m_axis_tready <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_idx     <= '0;
        i_cfg_data    <= '0;
        cycles        = 0;
        mismatches    = 0;
        burst_left    = 0;
        stall_phase   = 0;
        stall_mode    = 0;
        foreach (base_regs[i]) base_regs[i] = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_single_point();
        test_coords_not_below_p();
        test_zero_denominator();
        test_unused_register_index();
        test_full_batch();
        test_random_batches();

        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
